/* rtl/txrcdi_pkg.sv */
// txrcdi_pkg: shared types and codes for the transmit ring chunk issue unit
// command/result beat structs, command and status codes, chunk cap
// no dependencies
`timescale 1ns / 1ps

package txrcdi_pkg;

    // command codes carried in the cmd field
    localparam logic [1:0] CMD_PUT   = 2'd0;
    localparam logic [1:0] CMD_FLUSH = 2'd1;
    localparam logic [1:0] CMD_FETCH = 2'd2;

    // status codes carried in the status field
    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_BUSY   = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_ISSUED = 2'd3;

    // chunk length cap and its register reset value
    localparam logic [8:0] CHUNK_CAP = 9'd256;

    // configuration port geometry
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam logic [0:0]  REG_MAX_CHUNK = 1'b0;

    // one command beat
    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  data_byte;
        logic [14:0] fetch_offset;
        logic        desc_busy;
    } req_t;

    // one result beat
    typedef struct packed {
        logic [1:0]  status;
        logic [14:0] chunk_start;
        logic [8:0]  chunk_length;
        logic [7:0]  read_byte;
    } rsp_t;

endpackage

/* rtl/tx_ring_chunked_descriptor_issue_unit.sv */
// tx_ring_chunked_descriptor_issue_unit: byte ring with put, flush and fetch commands
// holds the byte store memory, head/tail indices and the max_chunk register
// depends on txrcdi_pkg
`timescale 1ns / 1ps

// latency: a result beat is strobed on done in the cycle after the command is taken
// throughput: one command per cycle; the store write and registered
//   store read each finish in the accept cycle, so busy stays low
// reset: head and tail indices return to zero and max_chunk to 256 at once;
//   the byte store is not cleared, so no clearing pass is needed
// the result receiver cannot stall; each beat shows for exactly one cycle
module tx_ring_chunked_descriptor_issue_unit #(
    parameter int unsigned BUFFER_DEPTH = 32768
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // command side
    input  logic                                start,
    output logic                                busy,
    input  txrcdi_pkg::req_t                    request,
    // result side
    output logic                                done,
    output txrcdi_pkg::rsp_t                    result,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [txrcdi_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [txrcdi_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [txrcdi_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                                pready
);

    localparam int unsigned IW = (BUFFER_DEPTH > 2) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int unsigned LW = IW + 1;
    localparam int unsigned CW = (LW > 9) ? LW : 9;
    localparam logic [LW-1:0] DEPTH_L = LW'(BUFFER_DEPTH);
    localparam logic [IW-1:0] LAST_IDX = IW'(BUFFER_DEPTH - 1);

    // storage
    logic [7:0]    store_mem [BUFFER_DEPTH];
    logic [7:0]    rd_byte_reg;

    logic [IW-1:0] head_reg, head_next;
    logic [IW-1:0] tail_reg, tail_next;
    logic [8:0]    max_chunk_reg, max_chunk_next;
    logic          done_reg, done_next;
    logic [1:0]    status_reg, status_next;
    logic [14:0]   start_reg, start_next;
    logic [8:0]    len_reg, len_next;
    logic          fetch_reg, fetch_next;

    logic          accept;
    logic          cfg_write;
    logic          is_put, is_flush, is_fetch;
    logic [31:0]   off_l;
    logic          off_ok;
    logic [IW-1:0] rd_idx;
    logic [LW-1:0] run_len;
    logic [8:0]    limit;
    logic [CW-1:0] run_c, lim_c, len_c;
    logic [LW-1:0] tail_sum;
    logic [31:0]   start_wide;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign pready = 1'b1;

    assign is_put   = accept && (request.cmd == txrcdi_pkg::CMD_PUT);
    assign is_flush = accept && (request.cmd == txrcdi_pkg::CMD_FLUSH);
    assign is_fetch = accept && (request.cmd == txrcdi_pkg::CMD_FETCH);

    // configuration write decode and readback
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == txrcdi_pkg::REG_MAX_CHUNK)
                       ? {{(txrcdi_pkg::CFG_DATA_W - 9){1'b0}}, max_chunk_reg}
                       : '0;

    always_comb
    begin
        max_chunk_next = max_chunk_reg;
        if (cfg_write && (paddr[2] == txrcdi_pkg::REG_MAX_CHUNK))
        begin
            max_chunk_next = pwdata[8:0];
        end
    end

    // fetch address check, done at full offset width
    assign off_l  = 32'(request.fetch_offset);
    assign off_ok = (off_l < 32'(BUFFER_DEPTH));
    assign rd_idx = off_l[IW-1:0];

    // byte store write port
    always_ff @(posedge clk)
    begin
        if (is_put)
        begin
            store_mem[head_reg] <= request.data_byte;
        end
    end

    // byte store read port, registered
    always_ff @(posedge clk)
    begin
        if (is_fetch && off_ok)
        begin
            rd_byte_reg <= store_mem[rd_idx];
        end
    end

    // effective chunk limit: zero acts as one, above the cap acts as the cap
    always_comb
    begin
        if (max_chunk_reg == 9'd0)
        begin
            limit = 9'd1;
        end
        else if (max_chunk_reg > txrcdi_pkg::CHUNK_CAP)
        begin
            limit = txrcdi_pkg::CHUNK_CAP;
        end
        else
        begin
            limit = max_chunk_reg;
        end
    end

    // contiguous run from the tail, capped at the limit
    always_comb
    begin
        if (tail_reg < head_reg)
        begin
            run_len = LW'(head_reg) - LW'(tail_reg);
        end
        else
        begin
            run_len = DEPTH_L - LW'(tail_reg);
        end
        run_c = CW'(run_len);
        lim_c = CW'(limit);
        len_c = (run_c > lim_c) ? lim_c : run_c;
    end

    // tail after this chunk is retired, wraps at the buffer end
    assign tail_sum   = LW'(tail_reg) + len_c[LW-1:0];
    assign start_wide = 32'(tail_reg);

    // head advance on a put
    always_comb
    begin
        head_next = head_reg;
        if (is_put)
        begin
            head_next = (head_reg == LAST_IDX) ? '0 : head_reg + IW'(1);
        end
    end

    // result beat and tail update
    always_comb
    begin
        tail_next   = tail_reg;
        done_next   = accept;
        status_next = txrcdi_pkg::ST_DONE;
        start_next  = 15'd0;
        len_next    = 9'd0;
        fetch_next  = is_fetch && off_ok;
        if (is_flush)
        begin
            if (request.desc_busy)
            begin
                status_next = txrcdi_pkg::ST_BUSY;
            end
            else if (tail_reg == head_reg)
            begin
                status_next = txrcdi_pkg::ST_EMPTY;
            end
            else
            begin
                status_next = txrcdi_pkg::ST_ISSUED;
                start_next  = start_wide[14:0];
                len_next    = len_c[8:0];
                tail_next   = (tail_sum == DEPTH_L) ? '0 : tail_sum[IW-1:0];
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            max_chunk_reg <= txrcdi_pkg::CHUNK_CAP;
            done_reg      <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            max_chunk_reg <= max_chunk_next;
            done_reg      <= done_next;
        end
    end

    // result payload registers
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        start_reg  <= start_next;
        len_reg    <= len_next;
        fetch_reg  <= fetch_next;
    end

    // result beat
    assign done                = done_reg;
    assign result.status       = status_reg;
    assign result.chunk_start  = start_reg;
    assign result.chunk_length = len_reg;
    assign result.read_byte    = fetch_reg ? rd_byte_reg : 8'd0;

    // checks
    a_done_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept))
        else $error("result beat without a taken command");

    a_issue_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status == txrcdi_pkg::ST_ISSUED)) |-> (result.chunk_length != 9'd0))
        else $error("issued chunk has zero length");

    a_no_issue_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status != txrcdi_pkg::ST_ISSUED))
        |-> ((result.chunk_length == 9'd0) && (result.chunk_start == 15'd0)))
        else $error("chunk fields set without an issue");

    a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
        LW'(head_reg) < DEPTH_L)
        else $error("head index out of range");

    a_tail_moves_on_issue: assert property (@(posedge clk) disable iff (!rst_n)
        (tail_reg != $past(tail_reg)) |-> (done && (result.status == txrcdi_pkg::ST_ISSUED)))
        else $error("tail moved without an issued chunk");

endmodule
